[hw/rtl/esht_pkg.sv]
// Package for the ELF symbol hash table insert block.
// Holds field widths, operation and status codes, state and command types.
// No dependencies; imported by every module of the block.
package esht_pkg;

  // Field and register widths.
  localparam int HASH_W      = 28;
  localparam int SYM_W       = 10;
  localparam int BYTE_W      = 8;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int BCNT_W      = 9;
  localparam int CCNT_W      = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  // Restoring division of the hash, one quotient bit per step.
  localparam int DIV_STEPS = HASH_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration reset values.
  localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 9'd256;
  localparam logic [CCNT_W-1:0] CHAIN_COUNT_RST  = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_NAME   = 2'd0,
    OP_RD_BKT = 2'd1,
    OP_RD_CHN = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 3'd0,
    STS_EMPTY = 3'd1,
    STS_ZERO  = 3'd2,
    STS_RANGE = 3'd3,
    STS_WALK  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUCKET_COUNT = 1'b0,
    CFG_CHAIN_COUNT  = 1'b1
  } cfg_reg_t;

  // What an accepted beat asks of the controller.
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_RESULT = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_RD_BKT = 3'd3,
    KIND_RD_CHN = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR       = 4'd0,
    S_IDLE        = 4'd1,
    S_DIV         = 4'd2,
    S_BKT_RD      = 4'd3,
    S_BKT_CHK     = 4'd4,
    S_WALK_RD     = 4'd5,
    S_WALK_CHK    = 4'd6,
    S_ZERO_OWN    = 4'd7,
    S_RD_BKT      = 4'd8,
    S_RD_BKT_DATA = 4'd9,
    S_RD_CHN      = 4'd10,
    S_RD_CHN_DATA = 4'd11,
    S_DONE        = 4'd12
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    accept;
    logic    div_step;
    logic    bkt_rd_rem;
    logic    bkt_rd_ridx;
    logic    bkt_wr_sym;
    logic    chn_rd_cur;
    logic    chn_rd_ridx;
    logic    chn_wr_sym;
    logic    chn_wr_zero;
    logic    cur_from_bkt;
    logic    cur_from_chn;
    logic    res_set;
    status_t res_code;
    logic    res_from_bkt;
    logic    res_from_chn;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  div_last;
    logic  bkt_zero;
    logic  chn_zero;
    logic  walk_bad;
    logic  out_free;
  } dp_sts_t;

endpackage

[hw/rtl/elf_symbol_hash_table_insert.sv]
// Each accepted beat is handled in turn: a rejected beat loads the result register directly, a
// read addresses a memory and captures its data, and an insert runs the 28-step serial divider,
// probes the bucket and, if it is taken, walks the chain one entry at a time through the single
// chain memory read port before the append.
// Throughput: one item at a time, the next beat taken the cycle after the result loads; name
// bytes are taken one per cycle while idle. Reset: a sweep zeroes both memories, tready low.
module elf_symbol_hash_table_insert
  import esht_pkg::*;
#(
  parameter int BUCKET_DEPTH = 256,
  parameter int CHAIN_DEPTH  = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // name_byte, symbol_index, read_index
  input  logic [OP_W-1:0]        s_axis_tuser,  // op
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, hash_value, read_data
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [STATUS_W-1:0] out_status;
  logic [HASH_W-1:0]   out_hash;
  logic [SYM_W-1:0]    out_data;

  esht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esht_dp #(
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .CHAIN_DEPTH  (CHAIN_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (s_axis_tuser),
    .name_byte    (s_axis_tdata[BYTE_W-1:0]),
    .symbol_index (s_axis_tdata[BYTE_W+SYM_W-1:BYTE_W]),
    .read_index   (s_axis_tdata[BYTE_W+2*SYM_W-1:BYTE_W+SYM_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_status   (out_status),
    .out_hash     (out_hash),
    .out_data     (out_data)
  );

  // Pack the result beat, status in the lowest bits, padded to whole bytes.
  assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - HASH_W - SYM_W){1'b0}},
                         out_data, out_hash, out_status};

endmodule

[hw/rtl/esht_dp.sv]
// Datapath of the ELF symbol hash table: config registers, hash fold,
// serial divider, bucket and chain memories, chain walk and output register.
// Depends on esht_pkg; driven by esht_ctrl through dp_cmd_t.
module esht_dp
  import esht_pkg::*;
#(
  parameter int BUCKET_DEPTH = 256,
  parameter int CHAIN_DEPTH  = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       op,
  input  logic [BYTE_W-1:0]     name_byte,
  input  logic [SYM_W-1:0]      symbol_index,
  input  logic [SYM_W-1:0]      read_index,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [HASH_W-1:0]     out_hash,
  output logic [SYM_W-1:0]      out_data
);

  localparam int BIW       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CIW       = $clog2(CHAIN_DEPTH);
  localparam int MAX_DEPTH = (BUCKET_DEPTH > CHAIN_DEPTH) ? BUCKET_DEPTH : CHAIN_DEPTH;
  localparam int CLR_W     = $clog2(MAX_DEPTH);
  localparam int STEP_W    = $clog2(CHAIN_DEPTH + 1);

  logic [BCNT_W-1:0]    bucket_count;
  logic [CCNT_W-1:0]    chain_count;
  logic [BCNT_W-1:0]    eff_b;
  logic [CCNT_W-1:0]    eff_c;
  logic [HASH_W-1:0]    running_hash;
  logic                 name_started;
  kind_t                kind;
  status_t              pre_code;
  logic [SYM_W-1:0]     sym_r;
  logic [SYM_W-1:0]     ridx_r;
  logic [HASH_W-1:0]    hash_r;
  logic [STATUS_W-1:0]  res_status;
  logic [SYM_W-1:0]     res_data;
  logic [HASH_W-1:0]    dividend;
  logic [BCNT_W-1:0]    rem;
  logic [BCNT_W:0]      rem_sh;
  logic [BCNT_W-1:0]    rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SYM_W-1:0]     cur;
  logic [STEP_W-1:0]    steps;
  logic [CLR_W-1:0]     clr;
  logic                 clr_in_bkt;
  logic                 clr_in_chn;
  logic [SYM_W-1:0]     bucket_mem [BUCKET_DEPTH];
  logic [SYM_W-1:0]     chain_mem  [CHAIN_DEPTH];
  logic [SYM_W-1:0]     bucket_q;
  logic [SYM_W-1:0]     chain_q;
  logic                 bkt_we;
  logic [BIW-1:0]       bkt_waddr;
  logic [SYM_W-1:0]     bkt_wdata;
  logic [BIW-1:0]       bkt_raddr;
  logic                 chn_we;
  logic [CIW-1:0]       chn_waddr;
  logic [SYM_W-1:0]     chn_wdata;
  logic [CIW-1:0]       chn_raddr;

  // One step of the ELF hash: shift in a byte, fold the top nibble back down.
  function automatic logic [HASH_W-1:0] elf_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W+3:0] t;
    logic [3:0]        g;
    t = {h, 4'b0000} + {{(HASH_W + 4 - BYTE_W){1'b0}}, b};
    g = t[HASH_W+3:HASH_W];
    return t[HASH_W-1:0] ^ {{(HASH_W - 8){1'b0}}, g, 4'b0000};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RST;
      chain_count  <= CHAIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BUCKET_COUNT: bucket_count <= cfg_data[BCNT_W-1:0];
        CFG_CHAIN_COUNT:  chain_count  <= cfg_data[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts, clamped to the memory depths; a zero bucket count is taken as one.
  always_comb begin
    if (bucket_count == '0) begin
      eff_b = BCNT_W'(1);
    end else if (32'(bucket_count) > BUCKET_DEPTH) begin
      eff_b = BCNT_W'(BUCKET_DEPTH);
    end else begin
      eff_b = bucket_count;
    end
    if (32'(chain_count) > CHAIN_DEPTH) begin
      eff_c = CCNT_W'(CHAIN_DEPTH);
    end else begin
      eff_c = chain_count;
    end
  end

  // Decode the beat on the input and the checks that need no memory.
  always_comb begin
    kind     = KIND_NONE;
    pre_code = STS_OK;
    case (op_t'(op))
      OP_NAME: begin
        if (name_byte == '0) begin
          kind = KIND_RESULT;
          if (!name_started) begin
            pre_code = STS_EMPTY;
          end else if (symbol_index == '0) begin
            pre_code = STS_ZERO;
          end else if ({1'b0, symbol_index} >= eff_c) begin
            pre_code = STS_RANGE;
          end else begin
            kind = KIND_INSERT;
          end
        end
      end
      OP_RD_BKT: begin
        if (read_index < {1'b0, eff_b}) begin
          kind = KIND_RD_BKT;
        end else begin
          kind     = KIND_RESULT;
          pre_code = STS_RANGE;
        end
      end
      OP_RD_CHN: begin
        if ({1'b0, read_index} < eff_c) begin
          kind = KIND_RD_CHN;
        end else begin
          kind     = KIND_RESULT;
          pre_code = STS_RANGE;
        end
      end
      default: kind = KIND_NONE;
    endcase
  end

  // Running hash of the name in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      name_started <= 1'b0;
    end else if (cmd.accept && op_t'(op) == OP_NAME) begin
      if (name_byte != '0) begin
        running_hash <= elf_fold(running_hash, name_byte);
        name_started <= 1'b1;
      end else begin
        running_hash <= '0;
        name_started <= 1'b0;
      end
    end
  end

  // Item registers and the pending result.
  always_ff @(posedge clk) begin
    if (cmd.accept && kind != KIND_NONE) begin
      sym_r      <= symbol_index;
      ridx_r     <= read_index;
      res_status <= pre_code;
      res_data   <= '0;
      hash_r     <= (op_t'(op) == OP_NAME) ? running_hash : '0;
    end else begin
      if (cmd.res_set) begin
        res_status <= cmd.res_code;
      end
      if (cmd.res_from_bkt) begin
        res_data <= bucket_q;
      end else if (cmd.res_from_chn) begin
        res_data <= chain_q;
      end
    end
  end

  // Serial remainder of the hash by the bucket count.
  assign rem_sh   = {rem, dividend[HASH_W-1]};
  assign rem_next = (rem_sh >= {1'b0, eff_b}) ? BCNT_W'(rem_sh - {1'b0, eff_b})
                                              : rem_sh[BCNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dividend <= running_hash;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[HASH_W-2:0], 1'b0};
      rem      <= rem_next;
      div_cnt  <= div_cnt + 1'b1;
    end
  end

  // Chain walk pointer and step count.
  always_ff @(posedge clk) begin
    if (cmd.cur_from_bkt) begin
      cur   <= bucket_q;
      steps <= '0;
    end else if (cmd.cur_from_chn) begin
      cur   <= chain_q;
      steps <= steps + 1'b1;
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + 1'b1;
    end
  end

  assign clr_in_bkt = 32'(clr) < BUCKET_DEPTH;
  assign clr_in_chn = 32'(clr) < CHAIN_DEPTH;

  // Bucket memory port selection.
  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = BIW'(rem);
    bkt_wdata = sym_r;
    if (cmd.clr_step) begin
      bkt_we    = clr_in_bkt;
      bkt_waddr = BIW'(clr);
      bkt_wdata = '0;
    end else if (cmd.bkt_wr_sym) begin
      bkt_we = 1'b1;
    end
    bkt_raddr = cmd.bkt_rd_rem ? BIW'(rem) : BIW'(ridx_r);
  end

  // Chain memory port selection.
  always_comb begin
    chn_we    = 1'b0;
    chn_waddr = CIW'(cur);
    chn_wdata = sym_r;
    if (cmd.clr_step) begin
      chn_we    = clr_in_chn;
      chn_waddr = CIW'(clr);
      chn_wdata = '0;
    end else if (cmd.chn_wr_sym) begin
      chn_we = 1'b1;
    end else if (cmd.chn_wr_zero) begin
      chn_we    = 1'b1;
      chn_waddr = CIW'(sym_r);
      chn_wdata = '0;
    end
    chn_raddr = cmd.chn_rd_cur ? CIW'(cur) : CIW'(ridx_r);
  end

  // Bucket memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bucket_mem[bkt_waddr] <= bkt_wdata;
    end
    if (cmd.bkt_rd_rem || cmd.bkt_rd_ridx) begin
      bucket_q <= bucket_mem[bkt_raddr];
    end
  end

  // Chain memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (chn_we) begin
      chain_mem[chn_waddr] <= chn_wdata;
    end
    if (cmd.chn_rd_cur || cmd.chn_rd_ridx) begin
      chain_q <= chain_mem[chn_raddr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_hash   <= hash_r;
      out_data   <= res_data;
    end
  end

  // Status back to the controller.
  assign sts.clr_last = 32'(clr) == MAX_DEPTH - 1;
  assign sts.kind     = kind;
  assign sts.div_last = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.bkt_zero = bucket_q == '0;
  assign sts.chn_zero = chain_q == '0;
  assign sts.walk_bad = (32'(steps) == CHAIN_DEPTH) || (32'(cur) >= CHAIN_DEPTH);
  assign sts.out_free = !out_valid || out_ready;

endmodule

[hw/rtl/esht_ctrl.sv]
// Controller state machine of the ELF symbol hash table.
// Sequences the clearing sweep, the division, bucket probe and chain walk, and the table reads.
// Depends on esht_pkg; commands esht_dp.
module esht_ctrl
  import esht_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (sts.kind)
            KIND_RESULT: state_next = S_DONE;
            KIND_INSERT: state_next = S_DIV;
            KIND_RD_BKT: state_next = S_RD_BKT;
            KIND_RD_CHN: state_next = S_RD_CHN;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_BKT_RD;
      end
      S_BKT_RD:      state_next = S_BKT_CHK;
      S_BKT_CHK:     state_next = sts.bkt_zero ? S_DONE : S_WALK_RD;
      S_WALK_RD:     state_next = sts.walk_bad ? S_DONE : S_WALK_CHK;
      S_WALK_CHK:    state_next = sts.chn_zero ? S_ZERO_OWN : S_WALK_RD;
      S_ZERO_OWN:    state_next = S_DONE;
      S_RD_BKT:      state_next = S_RD_BKT_DATA;
      S_RD_BKT_DATA: state_next = S_DONE;
      S_RD_CHN:      state_next = S_RD_CHN_DATA;
      S_RD_CHN_DATA: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:       state_next = S_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd          = '0;
    cmd.res_code = STS_OK;
    in_ready     = 1'b0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DIV:    cmd.div_step = 1'b1;
      S_BKT_RD: cmd.bkt_rd_rem = 1'b1;
      S_BKT_CHK: begin
        if (sts.bkt_zero) begin
          cmd.bkt_wr_sym = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_code   = STS_OK;
        end else begin
          cmd.cur_from_bkt = 1'b1;
        end
      end
      S_WALK_RD: begin
        if (sts.walk_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STS_WALK;
        end else begin
          cmd.chn_rd_cur = 1'b1;
        end
      end
      S_WALK_CHK: begin
        if (sts.chn_zero) begin
          cmd.chn_wr_sym = 1'b1;
        end else begin
          cmd.cur_from_chn = 1'b1;
        end
      end
      S_ZERO_OWN: begin
        cmd.chn_wr_zero = 1'b1;
        cmd.res_set     = 1'b1;
        cmd.res_code    = STS_OK;
      end
      S_RD_BKT:      cmd.bkt_rd_ridx = 1'b1;
      S_RD_BKT_DATA: cmd.res_from_bkt = 1'b1;
      S_RD_CHN:      cmd.chn_rd_ridx = 1'b1;
      S_RD_CHN_DATA: cmd.res_from_chn = 1'b1;
      S_DONE:        cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // A result is never loaded over one that has not been taken.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  // The chain memory has one write port.
  a_chn_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.chn_wr_sym, cmd.chn_wr_zero}))
    else $error("more than one chain memory write in a cycle");

  // The own entry is zeroed only right after an append at a chain end.
  a_zero_after_append: assert property (@(posedge clk) disable iff (rst)
    (state == S_ZERO_OWN) |-> ($past(state) == S_WALK_CHK && $past(sts.chn_zero)))
    else $error("own chain entry zeroed without an append");

  // The divider runs its full count before the bucket probe.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !sts.div_last) |=> (state == S_DIV))
    else $error("division left early");
`endif

endmodule
